### hw/rtl/throttle_deadband_motor_sequencer_macros.svh
// Assertion helpers for the throttle sequencer. Both expect clk and rst in scope.
`ifndef THROTTLE_DEADBAND_MOTOR_SEQUENCER_MACROS_SVH
`define THROTTLE_DEADBAND_MOTOR_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define TDMS_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TDMS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tdms_pkg.sv
package tdms_pkg;

  localparam int RAW_W      = 16;
  localparam int DB_W       = 15;
  localparam int RPM_W      = 15;
  localparam int STATUS_W   = 3;
  localparam int PCT_W      = 7;
  localparam int PCT_OUT_W  = 8;
  localparam int SPEED_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 24;
  localparam int M_DATA_W   = 48;
  localparam int M_PAD_W    = 4;

  // quotient bits of the shared divider, and per-operation iteration counts
  localparam int QUO_W  = 16;
  localparam int QCNT_W = $clog2(QUO_W + 1);
  localparam logic [QCNT_W-1:0] PCT_ITERS  = QCNT_W'(7);
  localparam logic [QCNT_W-1:0] SPAN_ITERS = QCNT_W'(15);
  localparam logic [QCNT_W-1:0] SPD_ITERS  = QCNT_W'(16);

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'h7FFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_HALF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TOP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_BOTTOM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR_RPM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING_RPM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIME_MS      = 3'd6;

  localparam logic [RAW_W-1:0] CENTER_RST  = 16'd32768;
  localparam logic [DB_W-1:0]  DB_RST      = 15'd2000;
  localparam logic [RAW_W-1:0] TOP_RST     = 16'd65520;
  localparam logic [RAW_W-1:0] BOTTOM_RST  = 16'd0;
  localparam logic [RPM_W-1:0] FLOOR_RST   = 15'd1800;
  localparam logic [RPM_W-1:0] CEILING_RST = 15'd8000;
  localparam logic [RAW_W-1:0] RAMP_RST    = 16'd3000;

  localparam logic [STATUS_W-1:0] STATUS_IDLE       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_RUN        = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAULT_NOW  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAULT_OVER = 3'd3;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_FAULT_ACK = 3'd3,
    ACT_RAMP      = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGES,
    ST_MAP,
    ST_CLAMP,
    ST_PCT_MUL,
    ST_PCT_DIV,
    ST_DECIDE,
    ST_SPAN_MUL,
    ST_SPAN_DIV,
    ST_SPD_MUL,
    ST_SPD_DIV,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/tdms_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, stops early once the rest is zero.
module tdms_serial_mul #(
  parameter int AW = 16,
  parameter int BW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod,
  output logic             done
);

  localparam int PW = AW + BW;

  logic [PW-1:0] acc;
  logic [PW-1:0] ash;
  logic [BW-1:0] bsh;
  logic          busy;
  logic          last;

  assign last = ((bsh >> 1) == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= PW'(a);
      bsh <= b;
    end else if (busy) begin
      if (bsh[0]) begin
        acc <= acc + ash;
      end
      ash <= ash << 1;
      bsh <= bsh >> 1;
    end
  end

endmodule

### hw/rtl/tdms_serial_div.sv
// Restoring divider, one quotient bit per cycle, MSB first.
// Quotient must fit in nbits, or only its top bit is meaningful.
module tdms_serial_div #(
  parameter int NW = 26,
  parameter int DW = 16,
  parameter int QB = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NW-1:0]             num,
  input  logic [DW-1:0]             den,
  input  logic [$clog2(QB+1)-1:0]   nbits,
  output logic [QB-1:0]             quo,
  output logic                      done
);

  localparam int CNTW = $clog2(QB + 1);
  localparam int SW   = DW + QB - 1;
  localparam int CW   = (NW > SW) ? NW : SW;

  logic [CW-1:0]   rem;
  logic [SW-1:0]   dsh;
  logic [CW-1:0]   dwide;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            ge;

  assign dwide = CW'(dsh);
  assign ge    = (rem >= dwide);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= CW'(num);
      dsh <= SW'(den) << (nbits - CNTW'(1));
      cnt <= nbits;
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dwide;
      end
      quo <= {quo[QB-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - CNTW'(1);
    end
  end

endmodule

### hw/rtl/throttle_deadband_motor_sequencer.sv
// Channel   Dir  Transfer fields (tdata, lowest bit up)
// s_*       in   pot_sample[15:0], motor_status[18:16], zero pad
// m_*       out  throttle_percent[7:0], action[10:8], target_speed[26:11],
//                ramp_duration[42:27], is_running[43], zero pad
// cfg_*     in   one register write per cycle with cfg_we high
//
// One sample at a time. A sample inside the deadband or with an empty range skips the
// arithmetic; any other runs the shift-add multiplier and restoring divider for the
// percentage, a start runs them again for the speed, and a ramp runs them for the span
// and then for the speed. How long the span multiply takes depends on the percentage.
// A finished result waits in the output register while the next sample runs; a second
// result holds in ST_DONE until that one transfers. rst loads defaults and idle state.
`include "throttle_deadband_motor_sequencer_macros.svh"

module throttle_deadband_motor_sequencer #(
  parameter int SPEED_SCALE_NUM = 10,
  parameter int SPEED_SCALE_DEN = 60
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tdms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [tdms_pkg::S_DATA_W-1:0]    s_tdata,   // pot_sample, motor_status
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [tdms_pkg::M_DATA_W-1:0]    m_tdata    // pct, action, speed, ramp, running
);

  localparam int NUM_W = $clog2(SPEED_SCALE_NUM + 1);
  localparam int DEN_W = $clog2(SPEED_SCALE_DEN + 1);
  localparam int MB    = (NUM_W > tdms_pkg::PCT_W) ? NUM_W : tdms_pkg::PCT_W;
  localparam int PW    = tdms_pkg::RAW_W + MB;
  localparam int DW    = (DEN_W > tdms_pkg::RAW_W) ? DEN_W : tdms_pkg::RAW_W;

  // configuration
  logic [tdms_pkg::RAW_W-1:0] throttle_center;
  logic [tdms_pkg::DB_W-1:0]  deadband_half;
  logic [tdms_pkg::RAW_W-1:0] travel_top;
  logic [tdms_pkg::RAW_W-1:0] travel_bottom;
  logic [tdms_pkg::RPM_W-1:0] speed_floor_rpm;
  logic [tdms_pkg::RPM_W-1:0] speed_ceiling_rpm;
  logic [tdms_pkg::RAW_W-1:0] ramp_time_ms;

  tdms_pkg::state_t  state;
  tdms_pkg::state_t  state_next;
  tdms_pkg::action_t act_r;
  tdms_pkg::action_t act_next;
  logic              running;
  logic              run_next;

  logic [tdms_pkg::RAW_W-1:0]    sample_r;
  logic [tdms_pkg::STATUS_W-1:0] status_r;
  logic [tdms_pkg::RAW_W:0]      hi_r;
  logic signed [tdms_pkg::RAW_W+1:0] lo_r;
  logic                          up_r;
  logic                          dn_r;
  logic [tdms_pkg::RAW_W-1:0]    val_r;
  logic signed [tdms_pkg::RAW_W+1:0] rng_r;
  logic [tdms_pkg::PCT_W-1:0]    mag_r;
  logic                          neg_r;
  logic [tdms_pkg::SPEED_W-1:0]  speed_r;
  logic [tdms_pkg::RAW_W-1:0]    dur_r;

  // mapping
  logic                              up_c;
  logic                              dn_c;
  logic signed [tdms_pkg::RAW_W+1:0] rng_up;
  logic signed [tdms_pkg::RAW_W+1:0] rng_dn;
  logic [tdms_pkg::RAW_W-1:0]        rng16;
  logic [tdms_pkg::RAW_W-1:0]        clamp_c;
  logic                              zero_c;
  logic                              pct_nz;
  logic [tdms_pkg::PCT_OUT_W-1:0]    pct_mag8;
  logic [tdms_pkg::PCT_OUT_W-1:0]    pct_out;

  // speed
  logic signed [tdms_pkg::RPM_W:0] span;
  logic [tdms_pkg::RPM_W-1:0]      span_abs;
  logic [tdms_pkg::RPM_W:0]        rpm_sum;
  logic [tdms_pkg::RPM_W-1:0]      rpm_next;
  logic [tdms_pkg::SPEED_W-1:0]    q_mag16;
  logic [tdms_pkg::SPEED_W-1:0]    speed_fin;

  // arithmetic units
  logic                        mul_start;
  logic [tdms_pkg::RAW_W-1:0]  mul_a;
  logic [MB-1:0]               mul_b;
  logic [PW-1:0]               mul_prod;
  logic                        mul_done;
  logic [DW-1:0]               div_den;
  logic [tdms_pkg::QCNT_W-1:0] div_nbits;
  logic [tdms_pkg::QUO_W-1:0]  div_quo;
  logic                        div_done;
  logic                        out_free;
  logic                        out_load;

  // output fields for checks
  tdms_pkg::action_t            m_act;
  logic                         m_run;
  logic [tdms_pkg::SPEED_W-1:0] m_spd;
  logic                         m_speed_cmd;

  tdms_serial_mul #(
    .AW (tdms_pkg::RAW_W),
    .BW (MB)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  tdms_serial_div #(
    .NW (PW),
    .DW (DW),
    .QB (tdms_pkg::QUO_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (mul_done),
    .num   (mul_prod),
    .den   (div_den),
    .nbits (div_nbits),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_center   <= tdms_pkg::CENTER_RST;
      deadband_half     <= tdms_pkg::DB_RST;
      travel_top        <= tdms_pkg::TOP_RST;
      travel_bottom     <= tdms_pkg::BOTTOM_RST;
      speed_floor_rpm   <= tdms_pkg::FLOOR_RST;
      speed_ceiling_rpm <= tdms_pkg::CEILING_RST;
      ramp_time_ms      <= tdms_pkg::RAMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tdms_pkg::REG_THROTTLE_CENTER:   throttle_center   <= cfg_data;
        tdms_pkg::REG_DEADBAND_HALF:     deadband_half     <= cfg_data[tdms_pkg::DB_W-1:0];
        tdms_pkg::REG_TRAVEL_TOP:        travel_top        <= cfg_data;
        tdms_pkg::REG_TRAVEL_BOTTOM:     travel_bottom     <= cfg_data;
        tdms_pkg::REG_SPEED_FLOOR_RPM:   speed_floor_rpm   <= cfg_data[tdms_pkg::RPM_W-1:0];
        tdms_pkg::REG_SPEED_CEILING_RPM: speed_ceiling_rpm <= cfg_data[tdms_pkg::RPM_W-1:0];
        tdms_pkg::REG_RAMP_TIME_MS:      ramp_time_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath terms
  always_comb begin
    up_c     = ({1'b0, sample_r} > hi_r);
    dn_c     = ($signed({2'b0, sample_r}) < lo_r);
    rng_up   = $signed({2'b0, travel_top}) - $signed({1'b0, hi_r});
    rng_dn   = lo_r - $signed({2'b0, travel_bottom});
    rng16    = rng_r[tdms_pkg::RAW_W-1:0];
    clamp_c  = (val_r > rng16) ? rng16 : val_r;
    zero_c   = !(up_r || dn_r) || rng_r[tdms_pkg::RAW_W+1] || (rng_r == '0);
    pct_nz   = (mag_r != '0);
    pct_mag8 = {1'b0, mag_r};
    pct_out  = neg_r ? -pct_mag8 : pct_mag8;
    span     = $signed({1'b0, speed_ceiling_rpm}) - $signed({1'b0, speed_floor_rpm});
    span_abs = span[tdms_pkg::RPM_W] ? tdms_pkg::RPM_W'(-span) : span[tdms_pkg::RPM_W-1:0];
    rpm_sum  = span[tdms_pkg::RPM_W]
             ? ({1'b0, speed_floor_rpm} - {1'b0, div_quo[tdms_pkg::RPM_W-1:0]})
             : ({1'b0, speed_floor_rpm} + {1'b0, div_quo[tdms_pkg::RPM_W-1:0]});
    rpm_next = rpm_sum[tdms_pkg::RPM_W-1:0];
    q_mag16  = {1'b0, div_quo[tdms_pkg::SPEED_W-2:0]};
    if (div_quo[tdms_pkg::QUO_W-1]) begin
      speed_fin = neg_r ? tdms_pkg::SPEED_MIN : tdms_pkg::SPEED_MAX;
    end else begin
      speed_fin = neg_r ? -q_mag16 : q_mag16;
    end
  end

  // sequencer decision
  always_comb begin
    act_next = tdms_pkg::ACT_NONE;
    run_next = running;
    if (!running) begin
      if (pct_nz && status_r == tdms_pkg::STATUS_IDLE) begin
        act_next = tdms_pkg::ACT_START;
        run_next = 1'b1;
      end else if (status_r == tdms_pkg::STATUS_FAULT_OVER) begin
        act_next = tdms_pkg::ACT_FAULT_ACK;
      end
    end else if (!pct_nz) begin
      act_next = tdms_pkg::ACT_STOP;
      run_next = 1'b0;
    end else if (status_r == tdms_pkg::STATUS_RUN) begin
      act_next = tdms_pkg::ACT_RAMP;
    end else if (status_r inside {tdms_pkg::STATUS_IDLE, tdms_pkg::STATUS_FAULT_NOW,
                                  tdms_pkg::STATUS_FAULT_OVER}) begin
      run_next = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tdms_pkg::ST_IDLE:     if (s_tvalid) state_next = tdms_pkg::ST_EDGES;
      tdms_pkg::ST_EDGES:    state_next = tdms_pkg::ST_MAP;
      tdms_pkg::ST_MAP:      state_next = tdms_pkg::ST_CLAMP;
      tdms_pkg::ST_CLAMP:    state_next = zero_c ? tdms_pkg::ST_DECIDE : tdms_pkg::ST_PCT_MUL;
      tdms_pkg::ST_PCT_MUL:  if (mul_done) state_next = tdms_pkg::ST_PCT_DIV;
      tdms_pkg::ST_PCT_DIV:  if (div_done) state_next = tdms_pkg::ST_DECIDE;
      tdms_pkg::ST_DECIDE: begin
        case (act_next)
          tdms_pkg::ACT_START: state_next = tdms_pkg::ST_SPD_MUL;
          tdms_pkg::ACT_RAMP:  state_next = tdms_pkg::ST_SPAN_MUL;
          default:             state_next = tdms_pkg::ST_DONE;
        endcase
      end
      tdms_pkg::ST_SPAN_MUL: if (mul_done) state_next = tdms_pkg::ST_SPAN_DIV;
      tdms_pkg::ST_SPAN_DIV: if (div_done) state_next = tdms_pkg::ST_SPD_MUL;
      tdms_pkg::ST_SPD_MUL:  if (mul_done) state_next = tdms_pkg::ST_SPD_DIV;
      tdms_pkg::ST_SPD_DIV:  if (div_done) state_next = tdms_pkg::ST_DONE;
      tdms_pkg::ST_DONE:     if (out_free) state_next = tdms_pkg::ST_IDLE;
      default:               state_next = tdms_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit control
  always_comb begin
    s_tready  = (state == tdms_pkg::ST_IDLE);
    out_free  = !m_tvalid || m_tready;
    out_load  = (state == tdms_pkg::ST_DONE) && out_free;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_den   = '0;
    div_nbits = tdms_pkg::SPD_ITERS;
    case (state)
      tdms_pkg::ST_CLAMP: begin
        mul_start = !zero_c;
        mul_a     = clamp_c;
        mul_b     = MB'(tdms_pkg::PCT_FULL);
      end
      tdms_pkg::ST_DECIDE: begin
        if (act_next == tdms_pkg::ACT_START) begin
          mul_start = 1'b1;
          mul_a     = {1'b0, speed_floor_rpm};
          mul_b     = MB'(SPEED_SCALE_NUM);
        end else if (act_next == tdms_pkg::ACT_RAMP) begin
          mul_start = 1'b1;
          mul_a     = {1'b0, span_abs};
          mul_b     = MB'(mag_r);
        end
      end
      tdms_pkg::ST_SPAN_DIV: begin
        mul_start = div_done;
        mul_a     = {1'b0, rpm_next};
        mul_b     = MB'(SPEED_SCALE_NUM);
      end
      tdms_pkg::ST_PCT_MUL: begin
        div_den   = DW'(rng16);
        div_nbits = tdms_pkg::PCT_ITERS;
      end
      tdms_pkg::ST_SPAN_MUL: begin
        div_den   = DW'(tdms_pkg::PCT_FULL);
        div_nbits = tdms_pkg::SPAN_ITERS;
      end
      tdms_pkg::ST_SPD_MUL: begin
        div_den   = DW'(SPEED_SCALE_DEN);
        div_nbits = tdms_pkg::SPD_ITERS;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tdms_pkg::ST_IDLE;
      running  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tdms_pkg::ST_DECIDE) begin
        running <= run_next;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tdms_pkg::ST_IDLE: begin
        sample_r <= s_tdata[tdms_pkg::RAW_W-1:0];
        status_r <= s_tdata[tdms_pkg::RAW_W +: tdms_pkg::STATUS_W];
      end
      tdms_pkg::ST_EDGES: begin
        hi_r <= {1'b0, throttle_center} + {2'b0, deadband_half};
        lo_r <= $signed({2'b0, throttle_center}) - $signed({3'b0, deadband_half});
      end
      tdms_pkg::ST_MAP: begin
        up_r  <= up_c;
        dn_r  <= dn_c && !up_c;
        val_r <= up_c ? (sample_r - hi_r[tdms_pkg::RAW_W-1:0])
                      : (lo_r[tdms_pkg::RAW_W-1:0] - sample_r);
        rng_r <= up_c ? rng_up : rng_dn;
      end
      tdms_pkg::ST_CLAMP: begin
        neg_r <= dn_r;
        if (zero_c) begin
          mag_r <= '0;
        end
      end
      tdms_pkg::ST_PCT_DIV: begin
        if (div_done) begin
          mag_r <= div_quo[tdms_pkg::PCT_W-1:0];
        end
      end
      tdms_pkg::ST_DECIDE: begin
        act_r   <= act_next;
        speed_r <= '0;
        dur_r   <= (act_next == tdms_pkg::ACT_RAMP) ? ramp_time_ms : '0;
      end
      tdms_pkg::ST_SPD_DIV: begin
        if (div_done) begin
          speed_r <= speed_fin;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      m_tdata <= {{tdms_pkg::M_PAD_W{1'b0}}, running, dur_r, speed_r, act_r, pct_out};
    end
  end

  assign m_act       = tdms_pkg::action_t'(m_tdata[10:8]);
  assign m_run       = m_tdata[43];
  assign m_spd       = m_tdata[26:11];
  assign m_speed_cmd = (m_act == tdms_pkg::ACT_START) || (m_act == tdms_pkg::ACT_RAMP);

  `TDMS_CHECK_IMP(a_cmd_runs, m_tvalid && m_speed_cmd, m_run, "start or ramp while idle")
  `TDMS_CHECK_IMP(a_stop, m_tvalid && m_act == tdms_pkg::ACT_STOP, !m_run, "stop while running")
  `TDMS_CHECK_IMP(a_speed_cmd, m_tvalid && m_spd != '0, m_speed_cmd, "speed without command")
  `TDMS_CHECK_NEXT(a_one_sample, s_tvalid && s_tready, !s_tready, "sample taken while busy")

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tdms_pkg::*;

  localparam int SCALE_NUM      = 10;
  localparam int SCALE_DEN      = 60;
  localparam int SETTLE_CYCLES  = 100;
  localparam int STALL_LIMIT    = 5000;
  localparam int IDLE_PCT       = 29;
  localparam int MAX_REPORTS    = 10;
  localparam int RAW_MAX        = 65535;

  localparam logic [STATUS_W-1:0] STATUS_OTHER    = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_ANY_LAST = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0]    sample;
    logic [STATUS_W-1:0] status;
  } sample_t;

  typedef struct packed {
    logic [PCT_OUT_W-1:0] pct;
    action_t              action;
    logic [SPEED_W-1:0]   speed;
    logic [RAW_W-1:0]     ramp;
    logic                 running;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  sample_t  samples_to_send[$];
  command_t predicted_commands[$];
  command_t want_cmd;
  command_t got_cmd;

  int cfg_center  = int'(CENTER_RST);
  int cfg_db      = int'(DB_RST);
  int cfg_top     = int'(TOP_RST);
  int cfg_bottom  = int'(BOTTOM_RST);
  int cfg_floor   = int'(FLOOR_RST);
  int cfg_ceiling = int'(CEILING_RST);
  int cfg_ramp    = int'(RAMP_RST);
  bit motor_running = 1'b0;

  bit steady = 1'b0;
  int mismatches = 0;
  int stall_count = 0;
  int items_queued = 0;

  throttle_deadband_motor_sequencer #(
    .SPEED_SCALE_NUM(SCALE_NUM),
    .SPEED_SCALE_DEN(SCALE_DEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // ---------------- prediction ----------------

  function automatic int side_pct(input int val, input int range);
    if (range <= 0 || val <= 0) return 0;
    if (val > range) val = range;
    return (val * 100) / range;
  endfunction

  function automatic int throttle_pct(input int sample);
    int hi;
    int lo;
    hi = cfg_center + cfg_db;
    lo = cfg_center - cfg_db;
    if (sample > hi) return side_pct(sample - hi, cfg_top - hi);
    if (sample < lo) return -side_pct(lo - sample, lo - cfg_bottom);
    return 0;
  endfunction

  function automatic logic [SPEED_W-1:0] rpm_to_speed(input int rpm);
    int v;
    v = (rpm * SCALE_NUM) / SCALE_DEN;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SPEED_W-1:0];
  endfunction

  // updates motor_running as the sequencer would
  function automatic command_t predict_command(input logic [RAW_W-1:0] sample,
                                               input logic [STATUS_W-1:0] status);
    command_t c;
    int pct;
    int absp;
    int rpm;
    pct = throttle_pct(int'(sample));
    c.pct = pct[PCT_OUT_W-1:0];
    c.action = ACT_NONE;
    c.speed = '0;
    c.ramp = '0;
    if (!motor_running) begin
      if (pct != 0 && status == STATUS_IDLE) begin
        c.action = ACT_START;
        c.speed = rpm_to_speed(pct > 0 ? cfg_floor : -cfg_floor);
        motor_running = 1'b1;
      end else if (status == STATUS_FAULT_OVER) begin
        c.action = ACT_FAULT_ACK;
      end
    end else begin
      if (pct == 0) begin
        c.action = ACT_STOP;
        motor_running = 1'b0;
      end else if (status == STATUS_RUN) begin
        absp = pct > 0 ? pct : -pct;
        rpm = cfg_floor + ((cfg_ceiling - cfg_floor) * absp) / 100;
        if (pct < 0) rpm = -rpm;
        c.action = ACT_RAMP;
        c.speed = rpm_to_speed(rpm);
        c.ramp = cfg_ramp[RAW_W-1:0];
      end else if (status == STATUS_IDLE || status == STATUS_FAULT_NOW ||
                   status == STATUS_FAULT_OVER) begin
        motor_running = 1'b0;
      end
    end
    c.running = motor_running;
    return c;
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!s_tvalid || s_tready) begin
        if (samples_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata <= {{(S_DATA_W - RAW_W - STATUS_W){1'b0}},
                      samples_to_send[0].status, samples_to_send[0].sample};
          samples_to_send.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        predicted_commands.push_back(predict_command(s_tdata[RAW_W-1:0],
                                                     s_tdata[RAW_W +: STATUS_W]));
      if (m_tvalid && m_tready) begin
        got_cmd.pct = m_tdata[7:0];
        got_cmd.action = action_t'(m_tdata[10:8]);
        got_cmd.speed = m_tdata[26:11];
        got_cmd.ramp = m_tdata[42:27];
        got_cmd.running = m_tdata[43];
        if (predicted_commands.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transfer: m_tdata=%h", m_tdata);
        end else begin
          want_cmd = predicted_commands.pop_front();
          if (got_cmd.pct !== want_cmd.pct || got_cmd.action !== want_cmd.action ||
              got_cmd.speed !== want_cmd.speed || got_cmd.ramp !== want_cmd.ramp ||
              got_cmd.running !== want_cmd.running) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch pct %0d/%0d act %0d/%0d spd %0d/%0d ramp %0d/%0d run %0d/%0d",
                       $signed(want_cmd.pct), $signed(got_cmd.pct),
                       want_cmd.action, got_cmd.action,
                       $signed(want_cmd.speed), $signed(got_cmd.speed),
                       want_cmd.ramp, got_cmd.ramp, want_cmd.running, got_cmd.running);
          end
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // ---------------- stimulus ----------------

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_THROTTLE_CENTER:   cfg_center  = value & 16'hFFFF;
      REG_DEADBAND_HALF:     cfg_db      = value & 16'h7FFF;
      REG_TRAVEL_TOP:        cfg_top     = value & 16'hFFFF;
      REG_TRAVEL_BOTTOM:     cfg_bottom  = value & 16'hFFFF;
      REG_SPEED_FLOOR_RPM:   cfg_floor   = value & 16'h7FFF;
      REG_SPEED_CEILING_RPM: cfg_ceiling = value & 16'h7FFF;
      REG_RAMP_TIME_MS:      cfg_ramp    = value & 16'hFFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int center, input int db, input int top, input int bottom,
                           input int floor_rpm, input int ceil_rpm, input int ramp);
    write_reg(REG_THROTTLE_CENTER, center);
    write_reg(REG_DEADBAND_HALF, db);
    write_reg(REG_TRAVEL_TOP, top);
    write_reg(REG_TRAVEL_BOTTOM, bottom);
    write_reg(REG_SPEED_FLOOR_RPM, floor_rpm);
    write_reg(REG_SPEED_CEILING_RPM, ceil_rpm);
    write_reg(REG_RAMP_TIME_MS, ramp);
  endtask

  task automatic write_random_config();
    int center;
    int db;
    center = $urandom_range(16000, 48000);
    db = $urandom_range(0, 6000);
    write_all(center, db, $urandom_range(center + db + 500, RAW_MAX),
              $urandom_range(0, center - db - 500), $urandom_range(0, 6000),
              $urandom_range(0, 30000), $urandom_range(0, RAW_MAX));
  endtask

  task automatic queue_sample(input int sample, input logic [STATUS_W-1:0] status);
    sample_t s;
    if (sample < 0) sample = 0;
    if (sample > RAW_MAX) sample = RAW_MAX;
    s.sample = sample[RAW_W-1:0];
    s.status = status;
    samples_to_send.push_back(s);
    items_queued++;
  endtask

  // a sample outside the deadband where possible
  function automatic int live_sample();
    int hi;
    int lo;
    hi = cfg_center + cfg_db;
    lo = cfg_center - cfg_db;
    if (hi < RAW_MAX && ($urandom_range(0, 1) == 1 || lo <= 0))
      return $urandom_range(hi + 1, RAW_MAX);
    if (lo > 0)
      return $urandom_range(0, lo - 1);
    return $urandom_range(0, RAW_MAX);
  endfunction

  function automatic int band_sample();
    int hi;
    int lo;
    hi = cfg_center + cfg_db;
    lo = cfg_center - cfg_db;
    if (hi > RAW_MAX) hi = RAW_MAX;
    if (lo < 0) lo = 0;
    return $urandom_range(lo, hi);
  endfunction

  function automatic int edge_sample();
    case ($urandom_range(0, 7))
      0: return cfg_center + cfg_db;
      1: return cfg_center + cfg_db + 1;
      2: return cfg_center - cfg_db;
      3: return cfg_center - cfg_db - 1;
      4: return cfg_top + $urandom_range(0, 2) - 1;
      5: return cfg_bottom + $urandom_range(0, 2) - 1;
      6: return 0;
      default: return RAW_MAX;
    endcase
  endfunction

  function automatic int any_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, RAW_MAX);
    if (r < 65) return edge_sample();
    return live_sample();
  endfunction

  function automatic logic [STATUS_W-1:0] any_status();
    return STATUS_W'($urandom_range(0, 7));
  endfunction

  task automatic wait_for_drain();
    while (samples_to_send.size() != 0 || s_tvalid || predicted_commands.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly start/ramp/stop episodes, some noise
  task automatic run_phase(input int count);
    int target;
    int n;
    int r;
    target = items_queued + count;
    @(negedge clk);
    while (items_queued < target) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_sample(any_sample(), any_status());
      end else begin
        if ($urandom_range(0, 3) == 0) queue_sample(any_sample(), STATUS_FAULT_OVER);
        queue_sample(live_sample(), STATUS_IDLE);
        n = $urandom_range(1, 8);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 75) queue_sample(live_sample(), STATUS_RUN);
          else if (r < 90) queue_sample(edge_sample(), STATUS_RUN);
          else queue_sample(any_sample(),
                            STATUS_W'($urandom_range(STATUS_OTHER, STATUS_ANY_LAST)));
        end
        r = $urandom_range(0, 99);
        if (r < 50) queue_sample(band_sample(), any_status());
        else if (r < 70) queue_sample(live_sample(), STATUS_FAULT_NOW);
        else if (r < 80) queue_sample(live_sample(), $urandom_range(0, 1) ? STATUS_IDLE
                                                                          : STATUS_FAULT_OVER);
        else queue_sample(edge_sample(), STATUS_RUN);
      end
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset configuration: center 32768, band 30768..34768
    queue_sample(32768, STATUS_FAULT_OVER);
    queue_sample(RAW_MAX, STATUS_FAULT_OVER);
    queue_sample(0, STATUS_RUN);
    queue_sample(34768, STATUS_IDLE);
    queue_sample(34769, STATUS_IDLE);
    queue_sample(RAW_MAX, STATUS_IDLE);
    queue_sample(65520, STATUS_RUN);
    queue_sample(50000, STATUS_RUN);
    queue_sample(RAW_MAX, STATUS_ANY_LAST);
    queue_sample(0, STATUS_RUN);
    queue_sample(30768, STATUS_RUN);
    queue_sample(30767, STATUS_IDLE);
    queue_sample(0, STATUS_IDLE);
    queue_sample(10000, STATUS_FAULT_NOW);
    queue_sample(0, STATUS_IDLE);
    queue_sample(0, STATUS_IDLE);
    queue_sample(60000, STATUS_IDLE);
    queue_sample(20000, STATUS_FAULT_OVER);
    queue_sample(5000, STATUS_OTHER);
    queue_sample(RAW_MAX, STATUS_IDLE);
    queue_sample(40000, STATUS_OTHER);
    queue_sample(32768, STATUS_RUN);
    queue_sample(1, STATUS_ANY_LAST);
    wait_for_drain();

    run_phase(150);

    write_random_config();
    run_phase(170);

    // no deadband, center at the bottom end, widest speed span
    write_all(0, 0, RAW_MAX, 0, 0, 30000, RAW_MAX);
    run_phase(140);

    // upper side never entered, ceiling below floor
    write_all(RAW_MAX, 32767, RAW_MAX, 0, 30000, 0, 0);
    run_phase(140);

    // forward range zero, reverse range one count
    write_all(32768, 100, 32868, 32667, 1800, 8000, 3000);
    run_phase(100);

    write_reg(REG_UNUSED, RAW_MAX);
    write_random_config();
    steady = 1'b1;
    run_phase(170);
    steady = 1'b0;

    write_random_config();
    run_phase(170);

    if (mismatches == 0 && predicted_commands.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
